FILE: rtl/core/polynomial_value_and_derivatives_assert.svh
// ----------------------------------------------------------------------------
// polynomial value and derivatives: assertion macros
// shared property forms for the checks at the end of the top level
// ----------------------------------------------------------------------------
`ifndef POLYNOMIAL_VALUE_AND_DERIVATIVES_ASSERT_SVH
`define POLYNOMIAL_VALUE_AND_DERIVATIVES_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define PVD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent a fixed number of cycles later
`define PVD_ASSERT_DLY(lbl, clk, rst_n, ante, dly, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/pvd_pkg.sv
// ----------------------------------------------------------------------------
// pvd_pkg
// types, constants and register codes of the polynomial evaluator
// ----------------------------------------------------------------------------
package pvd_pkg;

    localparam int MAX_TERMS  = 6;
    localparam int FRAC_BITS  = 16;
    localparam int NUM_STEPS  = MAX_TERMS - 1;
    localparam int NUM_CHAINS = 3;
    localparam int PIPE_LAT   = 2 * NUM_STEPS + 2;

    localparam int X_W       = 32;
    localparam int ACC_W     = 64;
    localparam int COEF_W    = 40;
    localparam int CFG_IDX_W = 3;
    localparam int TERM_W    = 3;

    // chain lanes
    localparam int CH_VAL = 0;
    localparam int CH_D1  = 1;
    localparam int CH_D2  = 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TERM_COUNT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_COEFF_0    = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_COEFF_LAST = CFG_IDX_W'(MAX_TERMS);

    typedef logic signed [ACC_W-1:0]  t_acc;
    typedef logic signed [COEF_W-1:0] t_coef;
    typedef t_coef [NUM_CHAINS-1:0]   t_kset;

    // accumulator limits
    localparam logic [ACC_W-1:0] ACC_LIM_U = ACC_W'(1) << 62;
    localparam t_acc ACC_LIM = t_acc'(ACC_LIM_U);
    localparam t_acc ACC_MIN = -ACC_LIM;
    localparam t_acc RES_MAX = t_acc'(32'sh7fff_ffff);
    localparam t_acc RES_MIN = t_acc'(-(64'sd1 <<< 31));

    // one pipeline word between horner steps
    typedef struct packed {
        logic                  sat;
        logic                  x_neg;
        logic [X_W-1:0]        x_mag;
        t_acc [NUM_CHAINS-1:0] acc;
    } t_stage;

endpackage

FILE: rtl/core/pvd_coeff.sv
// ----------------------------------------------------------------------------
// pvd_coeff
// configuration registers and the scaled coefficient sets of the three chains
// ----------------------------------------------------------------------------
module pvd_coeff import pvd_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [X_W-1:0]       i_cfg_data,
    output t_kset [MAX_TERMS-1:0] o_kset
);

    logic [TERM_W-1:0] r_term_count;
    logic [X_W-1:0]    r_coeff [MAX_TERMS];
    logic [CFG_IDX_W-1:0] coeff_sel;
    logic [TERM_W-1:0] n_eff;

    assign coeff_sel = i_cfg_index - REG_COEFF_0;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_term_count <= TERM_W'(1);
            for (int i = 0; i < MAX_TERMS; i++) begin
                r_coeff[i] <= '0;
            end
        end else if (i_cfg_we) begin
            unique case (i_cfg_index) inside
                REG_TERM_COUNT: r_term_count <= i_cfg_data[TERM_W-1:0];
                [REG_COEFF_0:REG_COEFF_LAST]: r_coeff[coeff_sel] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // term count clamped to 1..MAX_TERMS
    always_comb begin
        if (r_term_count == '0) begin
            n_eff = TERM_W'(1);
        end else if (r_term_count > TERM_W'(MAX_TERMS)) begin
            n_eff = TERM_W'(MAX_TERMS);
        end else begin
            n_eff = r_term_count;
        end
    end

    // coefficients of value, first and second derivative, zero above the degree
    always_comb begin
        o_kset = '0;
        for (int i = 0; i < MAX_TERMS; i++) begin
            if (i < int'(n_eff)) begin
                o_kset[i][CH_VAL] = t_coef'($signed(r_coeff[i]));
            end
        end
        for (int i = 0; i < MAX_TERMS - 1; i++) begin
            if (i + 1 < int'(n_eff)) begin
                o_kset[i][CH_D1] = t_coef'($signed(r_coeff[i+1])) * t_coef'(i + 1);
            end
        end
        for (int i = 0; i < MAX_TERMS - 2; i++) begin
            if (i + 2 < int'(n_eff)) begin
                o_kset[i][CH_D2] = t_coef'($signed(r_coeff[i+2]))
                                 * t_coef'((i + 1) * (i + 2));
            end
        end
    end

endmodule

FILE: rtl/core/pvd_horner_step.sv
// ----------------------------------------------------------------------------
// pvd_horner_step
// one horner step for all three chains: multiply stage, then round and add
// ----------------------------------------------------------------------------
module pvd_horner_step import pvd_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    input  t_stage i_stage,
    input  t_kset  i_kset,
    output logic   o_valid,
    output t_stage o_stage
);

    localparam int SHIFT = 32 - FRAC_BITS;
    localparam logic [ACC_W-1:0] HI_LIM = ACC_LIM_U >> SHIFT;
    localparam logic [ACC_W-1:0] RND = (FRAC_BITS > 0) ?
        (ACC_W'(1) << ((FRAC_BITS > 0) ? FRAC_BITS - 1 : 0)) : ACC_W'(0);

    typedef struct packed {
        logic                             sat;
        logic                             x_neg;
        logic [X_W-1:0]                   x_mag;
        logic [NUM_CHAINS-1:0]            neg;
        logic [NUM_CHAINS-1:0][ACC_W-1:0] lo;
        logic [NUM_CHAINS-1:0][ACC_W-2:0] hi;
    } t_prod;

    t_prod  r_p, n_p;
    logic   r_p_valid;
    t_stage r_s, n_s;
    logic   r_s_valid;

    // magnitudes and partial products
    always_comb begin
        t_acc a;
        logic [ACC_W-1:0] am;
        n_p.sat   = i_stage.sat;
        n_p.x_neg = i_stage.x_neg;
        n_p.x_mag = i_stage.x_mag;
        for (int c = 0; c < NUM_CHAINS; c++) begin
            a  = i_stage.acc[c];
            am = a[ACC_W-1] ? ACC_W'(-a) : ACC_W'(a);
            n_p.neg[c] = a[ACC_W-1] ^ i_stage.x_neg;
            n_p.lo[c]  = {32'd0, am[31:0]} * {32'd0, i_stage.x_mag};
            n_p.hi[c]  = {32'd0, am[ACC_W-2:32]} * {31'd0, i_stage.x_mag};
        end
    end

    // rounding, sign, coefficient add and accumulator clip
    always_comb begin
        logic [ACC_W-1:0] lo_r;
        logic [ACC_W-1:0] m;
        t_acc v;
        t_acc sum;
        logic sat;
        sat = r_p.sat;
        n_s.x_neg = r_p.x_neg;
        n_s.x_mag = r_p.x_mag;
        for (int c = 0; c < NUM_CHAINS; c++) begin
            lo_r = r_p.lo[c] + RND;
            if ({1'b0, r_p.hi[c]} > HI_LIM) begin
                m   = ACC_LIM_U;
                sat = 1'b1;
            end else begin
                m = ({1'b0, r_p.hi[c]} << SHIFT) + (lo_r >> FRAC_BITS);
                if (m > ACC_LIM_U) begin
                    m   = ACC_LIM_U;
                    sat = 1'b1;
                end
            end
            v   = r_p.neg[c] ? -t_acc'(m) : t_acc'(m);
            sum = v + t_acc'(i_kset[c]);
            if (sum > ACC_LIM) begin
                sum = ACC_LIM;
                sat = 1'b1;
            end else if (sum < ACC_MIN) begin
                sum = ACC_MIN;
                sat = 1'b1;
            end
            n_s.acc[c] = sum;
        end
        n_s.sat = sat;
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
            r_s_valid <= 1'b0;
        end else begin
            r_p_valid <= i_valid;
            r_s_valid <= r_p_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_p <= n_p;
        r_s <= n_s;
    end

    assign o_valid = r_s_valid;
    assign o_stage = r_s;

endmodule

FILE: rtl/core/pvd_out_clip.sv
// ----------------------------------------------------------------------------
// pvd_out_clip
// final clip of the three chains to 32 bits and the result register
// ----------------------------------------------------------------------------
module pvd_out_clip import pvd_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  t_stage                i_stage,
    output logic                  o_valid,
    output logic signed [X_W-1:0] o_poly_value,
    output logic signed [X_W-1:0] o_first_slope,
    output logic signed [X_W-1:0] o_second_slope,
    output logic                  o_saturated
);

    logic                             r_valid;
    logic [NUM_CHAINS-1:0][X_W-1:0]   r_res, n_res;
    logic                             r_sat, n_sat;

    // clip each chain
    always_comb begin
        t_acc a;
        n_sat = i_stage.sat;
        for (int c = 0; c < NUM_CHAINS; c++) begin
            a = i_stage.acc[c];
            if (a > RES_MAX) begin
                a     = RES_MAX;
                n_sat = 1'b1;
            end else if (a < RES_MIN) begin
                a     = RES_MIN;
                n_sat = 1'b1;
            end
            n_res[c] = a[X_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        r_sat <= n_sat;
    end

    assign o_valid        = r_valid;
    assign o_poly_value   = $signed(r_res[CH_VAL]);
    assign o_first_slope  = $signed(r_res[CH_D1]);
    assign o_second_slope = $signed(r_res[CH_D2]);
    assign o_saturated    = r_sat;

endmodule

FILE: rtl/core/polynomial_value_and_derivatives.sv
// ----------------------------------------------------------------------------
// polynomial_value_and_derivatives: p(x), p'(x), p''(x) in signed Q16.16
// a taken word passes the entry register, the horner steps and the result register
// one word per cycle, through five horner steps of two stages each
// reset clears the valid bits, term_count to 1 and coefficients to 0
// ----------------------------------------------------------------------------
`include "polynomial_value_and_derivatives_assert.svh"

module polynomial_value_and_derivatives import pvd_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic signed [X_W-1:0] i_argument,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [X_W-1:0]        i_cfg_data,
    output logic                  o_valid,
    output logic signed [X_W-1:0] o_poly_value,
    output logic signed [X_W-1:0] o_first_slope,
    output logic signed [X_W-1:0] o_second_slope,
    output logic                  o_saturated
);

    t_kset [MAX_TERMS-1:0] kset;
    t_stage                r_s0, n_s0;
    logic                  r_s0_valid;
    t_stage                st    [NUM_STEPS+1];
    logic                  st_vld[NUM_STEPS+1];

    // pipeline never holds off a word
    assign busy = 1'b0;

    pvd_coeff u_coeff (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_kset      (kset)
    );

    // entry stage: argument magnitude and the leading coefficient
    always_comb begin
        n_s0.sat   = 1'b0;
        n_s0.x_neg = i_argument[X_W-1];
        n_s0.x_mag = i_argument[X_W-1] ? X_W'(-i_argument) : X_W'(i_argument);
        n_s0.acc   = '0;
        n_s0.acc[CH_VAL] = t_acc'(kset[MAX_TERMS-1][CH_VAL]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else begin
            r_s0_valid <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s0 <= n_s0;
    end

    assign st[0]     = r_s0;
    assign st_vld[0] = r_s0_valid;

    // horner steps, highest coefficient first
    for (genvar k = 0; k < NUM_STEPS; k++) begin : g_step
        pvd_horner_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (st_vld[k]),
            .i_stage (st[k]),
            .i_kset  (kset[NUM_STEPS-1-k]),
            .o_valid (st_vld[k+1]),
            .o_stage (st[k+1])
        );
    end

    pvd_out_clip u_out (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (st_vld[NUM_STEPS]),
        .i_stage        (st[NUM_STEPS]),
        .o_valid        (o_valid),
        .o_poly_value   (o_poly_value),
        .o_first_slope  (o_first_slope),
        .o_second_slope (o_second_slope),
        .o_saturated    (o_saturated)
    );

    // every taken word leaves after the pipeline latency, and nothing else does
    `PVD_ASSERT_DLY(a_word_delivered, i_clk, i_rst_n, start && !busy, PIPE_LAT, o_valid, "taken word not delivered")
    `PVD_ASSERT_IMP(a_word_origin, i_clk, i_rst_n, o_valid, $past(start && !busy, PIPE_LAT), "result word without a start")

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: polynomial value and derivatives testbench
// Drives arguments through the start/busy handshake. The sender works in
// bursts separated by random gaps. Coefficients and the term count are
// reprogrammed only while the pipeline is empty. A local predictor follows
// the Horner chains, round-half-away products and clipping rules, and
// computes the expected word for every accepted argument. Each o_valid word
// is checked against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
    import pvd_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED  = CFG_IDX_W'(7);
    localparam int                   STALL_LIMIT = 2000;
    localparam int                   PHASES      = 12;
    localparam int                   PHASE_ITEMS = 120;

    typedef logic signed [127:0] t_wide;
    localparam t_wide ACC_BOUND = t_wide'(1) <<< 62;
    localparam t_wide OUT_MAX   = t_wide'(32'sh7fff_ffff);
    localparam t_wide OUT_MIN   = -(t_wide'(1) <<< 31);

    typedef struct packed {
        logic [X_W-1:0] value;
        logic [X_W-1:0] slope1;
        logic [X_W-1:0] slope2;
        logic           clip;
    } t_eval;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    logic signed [X_W-1:0] i_argument;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [X_W-1:0]        i_cfg_data;
    logic                  o_valid;
    logic signed [X_W-1:0] o_poly_value;
    logic signed [X_W-1:0] o_first_slope;
    logic signed [X_W-1:0] o_second_slope;
    logic                  o_saturated;

    // predictor copy of the registers
    logic [TERM_W-1:0]     model_terms;
    logic signed [X_W-1:0] model_coeff [MAX_TERMS];

    t_eval pending_results[$];
    int    mismatches;
    int    stall_cycles;
    int    burst_left;

    polynomial_value_and_derivatives dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_argument     (i_argument),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_valid        (o_valid),
        .o_poly_value   (o_poly_value),
        .o_first_slope  (o_first_slope),
        .o_second_slope (o_second_slope),
        .o_saturated    (o_saturated)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // acc * x, magnitude rounded half away from zero, clipped to 2^62
    function automatic t_wide scaled_product(input t_wide a, input t_wide x,
                                             inout logic clip);
        logic [127:0] ma;
        logic [127:0] mx;
        logic [127:0] m;
        logic         neg;
        neg = (a < 0) != (x < 0);
        ma  = (a < 0) ? -a : a;
        mx  = (x < 0) ? -x : x;
        m   = ma * mx;
        if (FRAC_BITS > 0)
            m = (m + (128'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        if (m > ACC_BOUND) begin
            clip = 1'b1;
            m    = ACC_BOUND;
        end
        return neg ? -$signed(m) : $signed(m);
    endfunction

    // one horner chain over n coefficients, result clipped to 32 bits
    function automatic logic [X_W-1:0] horner_chain(input t_wide k [MAX_TERMS], input int n,
                                                    input t_wide x, inout logic clip);
        t_wide acc;
        int    i;
        if (n <= 0)
            return '0;
        acc = k[n-1];
        for (i = n - 2; i >= 0; i--) begin
            acc = scaled_product(acc, x, clip) + k[i];
            if (acc > ACC_BOUND) begin
                clip = 1'b1;
                acc  = ACC_BOUND;
            end else if (acc < -ACC_BOUND) begin
                clip = 1'b1;
                acc  = -ACC_BOUND;
            end
        end
        if (acc > OUT_MAX) begin
            clip = 1'b1;
            acc  = OUT_MAX;
        end else if (acc < OUT_MIN) begin
            clip = 1'b1;
            acc  = OUT_MIN;
        end
        return acc[X_W-1:0];
    endfunction

    // value and both derivatives for one argument under the current registers
    function automatic t_eval eval_polynomial(input logic [X_W-1:0] arg);
        t_wide kv  [MAX_TERMS];
        t_wide kd  [MAX_TERMS];
        t_wide kdd [MAX_TERMS];
        t_wide x;
        t_wide c;
        int    n;
        int    i;
        logic  clip;
        t_eval r;
        x    = t_wide'($signed(arg));
        clip = 1'b0;
        n    = int'(model_terms);
        if (n < 1)
            n = 1;
        if (n > MAX_TERMS)
            n = MAX_TERMS;
        for (i = 0; i < MAX_TERMS; i++) begin
            kv[i]  = '0;
            kd[i]  = '0;
            kdd[i] = '0;
        end
        // derivative chains use the integer-scaled coefficients
        for (i = 0; i < n; i++) begin
            c     = t_wide'(model_coeff[i]);
            kv[i] = c;
            if (i >= 1)
                kd[i-1] = t_wide'(i) * c;
            if (i >= 2)
                kdd[i-2] = t_wide'(i * (i - 1)) * c;
        end
        r.value  = horner_chain(kv, n, x, clip);
        r.slope1 = horner_chain(kd, n - 1, x, clip);
        r.slope2 = horner_chain(kdd, n - 2, x, clip);
        r.clip   = clip;
        return r;
    endfunction

    // random Q16.16 values: mostly small, some full range, some corners
    function automatic logic [X_W-1:0] pick_corner();
        case ($urandom_range(0, 6))
            0:       return 32'h7fff_ffff;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'h0001_0000;
            4:       return 32'hffff_0000;
            5:       return 32'h0000_0001;
            default: return 32'hffff_ffff;
        endcase
    endfunction

    function automatic logic [X_W-1:0] pick_value(input int mag_bits);
        logic [X_W-1:0] v;
        v = $urandom();
        case ($urandom_range(0, 9))
            0:       return pick_corner();
            1, 2:    return v;
            default: begin
                v = v & ((32'd1 << mag_bits) - 1);
                if (v[mag_bits-1])
                    v = v | ~((32'd1 << mag_bits) - 1);
                return v;
            end
        endcase
    endfunction

    // register write, one cycle with the enable high
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [X_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        if (idx == REG_TERM_COUNT)
            model_terms = data[TERM_W-1:0];
        else if (idx >= REG_COEFF_0 && idx <= REG_COEFF_LAST)
            model_coeff[int'(idx - REG_COEFF_0)] = data;
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // one argument word through start/busy, then maybe a gap
    task automatic send_argument(input logic [X_W-1:0] x);
        start      <= 1'b1;
        i_argument <= x;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        pending_results.push_back(eval_polynomial(x));
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 8);
        end
    endtask

    // stop sending and wait until every word is back
    task automatic settle();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0)
            @(posedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic write_coeffs(input logic [X_W-1:0] c0, input logic [X_W-1:0] c1,
                                input logic [X_W-1:0] c2, input logic [X_W-1:0] c3,
                                input logic [X_W-1:0] c4, input logic [X_W-1:0] c5);
        write_reg(REG_COEFF_0,                    c0);
        write_reg(REG_COEFF_0 + CFG_IDX_W'(1), c1);
        write_reg(REG_COEFF_0 + CFG_IDX_W'(2), c2);
        write_reg(REG_COEFF_0 + CFG_IDX_W'(3), c3);
        write_reg(REG_COEFF_0 + CFG_IDX_W'(4), c4);
        write_reg(REG_COEFF_0 + CFG_IDX_W'(5), c5);
    endtask

    // reset registers give all zeros
    task automatic test_reset_state();
        send_argument(32'h0000_0000);
        send_argument(32'h7fff_ffff);
        send_argument(32'h8000_0000);
        settle();
    endtask

    // products on or just below half an lsb: exact ties round away from zero
    task automatic test_rounding_ties();
        write_reg(REG_TERM_COUNT, 32'd2);
        write_coeffs(32'd0, 32'd1, 32'd0, 32'd0, 32'd0, 32'd0);
        send_argument(32'h0000_8000);
        send_argument(32'hffff_8000);
        send_argument(32'h0000_7fff);
        send_argument(32'h0001_8000);
        settle();
    endtask

    // full degree with corner coefficients and corner arguments
    task automatic test_extreme_values();
        write_reg(REG_TERM_COUNT, 32'd6);
        write_coeffs(32'h0001_0000, 32'hfffe_0000, 32'h0000_8000,
                     32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff);
        send_argument(32'h0000_0000);
        send_argument(32'h0001_0000);
        send_argument(32'hffff_0000);
        send_argument(32'h0000_0001);
        send_argument(32'hffff_ffff);
        send_argument(32'h7fff_ffff);
        send_argument(32'h8000_0000);
        settle();
    endtask

    // term count zero and seven, short polynomials, unused index
    task automatic test_term_count_limits();
        write_reg(REG_UNUSED, $urandom());
        write_reg(REG_TERM_COUNT, 32'hffff_fff8);
        send_argument(32'h0001_0000);
        send_argument(32'h8000_0000);
        settle();
        write_reg(REG_TERM_COUNT, 32'd7);
        send_argument(32'h0001_0000);
        send_argument(32'hfffe_0000);
        settle();
        // second slope doubles c2 and clips
        write_reg(REG_TERM_COUNT, 32'd3);
        write_reg(REG_COEFF_0 + CFG_IDX_W'(2), 32'h7fff_ffff);
        send_argument(32'h0000_0000);
        settle();
        write_reg(REG_TERM_COUNT, 32'd2);
        send_argument(32'h0001_0000);
        settle();
    endtask

    // random register sets, each followed by a run of random arguments
    task automatic test_random_phases();
        logic [X_W-1:0] data;
        int             p;
        int             i;
        for (p = 0; p < PHASES; p++) begin
            if ($urandom_range(0, 3) == 0)
                write_reg(REG_UNUSED, $urandom());
            data      = $urandom();
            data[2:0] = ($urandom_range(0, 2) == 0) ? 3'd6 : 3'($urandom_range(0, 7));
            write_reg(REG_TERM_COUNT, data);
            for (i = 0; i < MAX_TERMS; i++)
                write_reg(REG_COEFF_0 + CFG_IDX_W'(i), pick_value(21));
            for (i = 0; i < PHASE_ITEMS; i++)
                send_argument(pick_value(18));
            settle();
        end
    endtask

    // compare each returned word with the oldest prediction
    always @(posedge i_clk) begin : check_results
        t_eval want;
        if (i_rst_n && o_valid) begin
            if (pending_results.size() == 0) begin
                $error("unexpected word: value %h", o_poly_value);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                if (o_poly_value !== want.value) begin
                    $error("poly_value: expected %h, got %h", want.value, o_poly_value);
                    mismatches++;
                end
                if (o_first_slope !== want.slope1) begin
                    $error("first_slope: expected %h, got %h", want.slope1, o_first_slope);
                    mismatches++;
                end
                if (o_second_slope !== want.slope2) begin
                    $error("second_slope: expected %h, got %h", want.slope2, o_second_slope);
                    mismatches++;
                end
                if (o_saturated !== want.clip) begin
                    $error("saturated: expected %b, got %b", want.clip, o_saturated);
                    mismatches++;
                end
            end
        end
    end

    // watchdog on cycles with no word moving either way
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("polynomial_value_and_derivatives: mismatch");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_argument  <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        mismatches   = 0;
        stall_cycles = 0;
        burst_left   = 0;
        model_terms  = TERM_W'(1);
        for (int i = 0; i < MAX_TERMS; i++)
            model_coeff[i] = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_rounding_ties();
        test_extreme_values();
        test_term_count_limits();
        test_random_phases();

        // drain, then watch for stray words
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (PIPE_LAT + 4) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("polynomial_value_and_derivatives: match");
        end else begin
            $display("polynomial_value_and_derivatives: mismatch");
        end
        $finish;
    end

endmodule
